// ===== sv/tile_layout_tree_parser_unit_assert.svh =====
// Assertion macros shared by the checker.
`ifndef TILE_LAYOUT_TREE_PARSER_UNIT_ASSERT_SVH
`define TILE_LAYOUT_TREE_PARSER_UNIT_ASSERT_SVH
`define TLTP_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("tltp check failed");
`define TLTP_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("tltp check failed");
`endif

// ===== sv/tltp_pkg.sv =====
package tltp_pkg;
  localparam int MaxSquares = 64;
  localparam int IdxW = $clog2(MaxSquares);
  localparam int CntW = $clog2(MaxSquares + 1);
  localparam logic [7:0] ByteEmpty = 8'h00;
  localparam logic [7:0] ByteEnd = 8'h40;
  localparam logic [3:0] ClsSquare = 4'hC;
  localparam logic [3:0] ClsPower = 4'h9;
  localparam logic [0:0] KindSquare = 1'b0;
  localparam logic [0:0] KindVerdict = 1'b1;

  typedef struct packed {
    logic [7:0] rbyte;
    logic fin;
  } req_t;

  typedef struct packed {
    logic kind;
    logic [7:0] px;
    logic [7:0] py;
    logic verdict;
    logic [6:0] total;
    logic last;
  } res_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] entry;
    logic [2:0] turn;
  } frame_t;
endpackage

// ===== sv/tltp_ram.sv =====
module tltp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/tltp_front.sv =====
// Small request queue between the port and the parser engine.
module tltp_front import tltp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_data,
  output logic full,
  input  logic pop,
  output req_t pop_data,
  output logic nempty
);
  req_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;

  assign full = cnt_r == 2'd2;
  assign nempty = cnt_r != 2'd0;
  assign pop_data = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push & ~full} - {1'b0, pop & nempty};
  end

  always_ff @(posedge clk) begin
    if (push && !full) q_r[wp_r] <= push_data;
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push && !full) wp_r <= ~wp_r;
      if (pop && nempty) rp_r <= ~rp_r;
    end
  end
endmodule

// ===== sv/tltp_back.sv =====
// Parser engine: one request at a time, duplicate scan over the position memory.
module tltp_back import tltp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [6:0] limit,
  input  logic       req_valid,
  input  req_t       req,
  output logic       req_pop,
  output logic       res_valid,
  output res_t       res,
  input  logic       res_take
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_DECIDE = 8'b00000100,
    S_SCAN  = 8'b00001000,
    S_PLACE = 8'b00010000,
    S_EMIT  = 8'b00100000,
    S_VERD  = 8'b01000000,
    S_RWAIT = 8'b10000000
  } st_t;
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001, PH_SIDE = 4'b0010, PH_TRAIL = 4'b0100, PH_DONE = 4'b1000
  } ph_t;

  st_t st_r, st_nxt;
  ph_t ph_r;
  req_t req_r;
  logic failed_r;
  logic [CntW-1:0] cnt_r, depth_r, scan_r;
  logic [8:0] nx_r, ny_r;
  logic [1:0] nent_r;
  frame_t top_r;
  logic scan_pend_r;

  logic pos_we, stk_we;
  logic [IdxW-1:0] pos_wa, pos_ra, stk_wa, stk_ra;
  logic [15:0] pos_wd, pos_rd;
  frame_t stk_wd, stk_rd;

  tltp_ram #(.Width(16), .Depth(MaxSquares)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd),
    .raddr(pos_ra), .rdata(pos_rd));
  tltp_ram #(.Width($bits(frame_t)), .Depth(MaxSquares)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .raddr(stk_ra), .rdata(stk_rd));

  logic [CntW-1:0] lim;
  logic [CntW-1:0] dm1;
  logic [1:0] dir;
  logic [8:0] cx, cy;
  logic place_ok_pre;
  logic [3:0] cls;

  always_comb begin
    lim = (limit > 7'(MaxSquares)) ? CntW'(MaxSquares) : CntW'(limit);
    dm1 = depth_r - 1'b1;
    cls = req_r.rbyte[7:4];
    dir = top_r.entry + top_r.turn[1:0];
    case (dir)
      2'd0: begin cx = {top_r.x[7], top_r.x}; cy = {top_r.y[7], top_r.y} - 9'd1; end
      2'd1: begin cx = {top_r.x[7], top_r.x} - 9'd1; cy = {top_r.y[7], top_r.y}; end
      2'd2: begin cx = {top_r.x[7], top_r.x}; cy = {top_r.y[7], top_r.y} + 9'd1; end
      default: begin cx = {top_r.x[7], top_r.x} + 9'd1; cy = {top_r.y[7], top_r.y}; end
    endcase
    place_ok_pre = (cnt_r < lim) && (nx_r[8] == nx_r[7]) && (ny_r[8] == ny_r[7])
                   && (depth_r < CntW'(MaxSquares));
    pos_ra = scan_r[IdxW-1:0];
    stk_ra = dm1[IdxW-1:0];
  end

  // Writes of the memories happen in S_PLACE and when a frame's turn advances.
  logic adv_we, unwind_r;
  always_comb begin
    pos_we = st_r == S_PLACE;
    pos_wa = cnt_r[IdxW-1:0];
    pos_wd = {nx_r[7:0], ny_r[7:0]};
    stk_we = (st_r == S_PLACE) || adv_we;
    stk_wa = (st_r == S_PLACE) ? depth_r[IdxW-1:0] : dm1[IdxW-1:0];
    stk_wd = (st_r == S_PLACE) ? frame_t'{nx_r[7:0], ny_r[7:0], nent_r, 3'd1}
                               : frame_t'{top_r.x, top_r.y, top_r.entry, top_r.turn + 3'd1};
  end

  assign req_pop = (st_r == S_IDLE) && req_valid;
  assign res_valid = (st_r == S_EMIT) || (st_r == S_VERD);

  always_comb begin
    res = '0;
    if (st_r == S_EMIT) begin
      res.kind = KindSquare;
      res.px = nx_r[7:0];
      res.py = ny_r[7:0];
      res.last = ~req_r.fin;
    end else begin
      res.kind = KindVerdict;
      res.verdict = failed_r || (ph_r != PH_DONE);
      res.total = (failed_r || (ph_r != PH_DONE)) ? 7'd0 : 7'(cnt_r);
      res.last = 1'b1;
    end
  end

  // Decide-step outcome.
  logic do_place, do_fail, do_unwind, to_done, to_trail;
  always_comb begin
    do_place = 1'b0; do_fail = 1'b0; do_unwind = 1'b0; to_done = 1'b0;
    to_trail = 1'b0; adv_we = 1'b0;
    if (st_r == S_DECIDE && !failed_r && !unwind_r) begin
      case (ph_r)
        PH_HEADER: if (cls == ClsSquare) do_place = 1'b1; else do_fail = 1'b1;
        PH_SIDE: begin
          if (depth_r == '0) do_fail = 1'b1;
          else begin
            adv_we = 1'b1;
            if (req_r.rbyte == ByteEnd) to_done = 1'b1;
            else if (req_r.rbyte == ByteEmpty) do_unwind = 1'b1;
            else if (cls == ClsSquare) do_place = 1'b1;
            else if (cls == ClsPower) to_trail = 1'b1;
            else do_fail = 1'b1;
          end
        end
        PH_TRAIL: if (req_r.rbyte == ByteEnd) to_done = 1'b1; else do_unwind = 1'b1;
        default: do_fail = 1'b1;
      endcase
    end
  end

  // After the stack depth changes, the registered read data shows the new top
  // frame only in the cycle after the read address changes.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (req_valid) st_nxt = S_READ;
      S_READ: st_nxt = S_DECIDE;
      S_DECIDE: begin
        if (unwind_r) st_nxt = (depth_r == '0 || top_r.turn <= 3'd3)
                               ? (req_r.fin ? S_VERD : S_IDLE) : S_RWAIT;
        else if (do_place) st_nxt = S_SCAN;
        else if (do_unwind) st_nxt = S_RWAIT;
        else st_nxt = req_r.fin ? S_VERD : S_IDLE;
      end
      S_RWAIT: st_nxt = S_READ;
      S_SCAN: begin
        if (!place_ok_pre || (scan_pend_r && pos_rd == {nx_r[7:0], ny_r[7:0]}))
          st_nxt = req_r.fin ? S_VERD : S_IDLE;
        else if (scan_r >= cnt_r && !scan_pend_r) st_nxt = S_PLACE;
      end
      S_PLACE: st_nxt = S_EMIT;
      S_EMIT: if (res_take) st_nxt = req_r.fin ? S_VERD : S_IDLE;
      S_VERD: if (res_take) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_pop) req_r <= req;
    if (st_r == S_READ) top_r <= stk_rd;
    if (adv_we) top_r.turn <= top_r.turn + 3'd1;
    if (st_r == S_DECIDE && do_place) begin
      if (ph_r == PH_HEADER) begin
        nx_r <= '0; ny_r <= '0; nent_r <= req_r.rbyte[1:0];
      end else begin
        nx_r <= cx; ny_r <= cy; nent_r <= dir + 2'd2;
      end
    end
    if (!rst_n) begin
      st_r <= S_IDLE;
      ph_r <= PH_HEADER;
      failed_r <= 1'b0;
      cnt_r <= '0;
      depth_r <= '0;
      scan_r <= '0;
      scan_pend_r <= 1'b0;
      unwind_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DECIDE) begin
        if (unwind_r) begin
          // Pop frames whose sides are all read.
          if (depth_r != '0 && top_r.turn > 3'd3) depth_r <= dm1;
          else begin
            unwind_r <= 1'b0;
            ph_r <= (depth_r == '0) ? PH_DONE : PH_SIDE;
          end
        end else begin
          if (do_fail) failed_r <= 1'b1;
          if (to_done) ph_r <= PH_DONE;
          if (to_trail) ph_r <= PH_TRAIL;
          if (do_unwind) begin
            unwind_r <= 1'b1;
            if (ph_r == PH_SIDE && top_r.turn >= 3'd3) depth_r <= dm1;
          end
          scan_r <= '0;
          scan_pend_r <= 1'b0;
        end
      end
      if (st_r == S_SCAN) begin
        if (!place_ok_pre || (scan_pend_r && pos_rd == {nx_r[7:0], ny_r[7:0]})) begin
          failed_r <= 1'b1;
        end else begin
          scan_pend_r <= scan_r < cnt_r;
          if (scan_r < cnt_r) scan_r <= scan_r + 1'b1;
        end
      end
      if (st_r == S_PLACE) begin
        cnt_r <= cnt_r + 1'b1;
        depth_r <= depth_r + 1'b1;
        ph_r <= PH_SIDE;
      end
      if (st_r == S_VERD && res_take) begin
        ph_r <= PH_HEADER;
        failed_r <= 1'b0;
        cnt_r <= '0;
        depth_r <= '0;
        unwind_r <= 1'b0;
      end
    end
  end
endmodule

// ===== sv/tltp_outq.sv =====
// Result register stage so the engine can finish while the sink stalls.
module tltp_outq import tltp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  res_t in_res,
  output logic in_take,
  output logic empty,
  output res_t out_res,
  input  logic pop
);
  logic full_r;
  res_t res_r;
  assign in_take = in_valid && (!full_r || pop);
  assign empty = ~full_r;
  assign out_res = res_r;
  always_ff @(posedge clk) begin
    if (in_take) res_r <= in_res;
    if (!rst_n) full_r <= 1'b0;
    else if (in_take) full_r <= 1'b1;
    else if (pop) full_r <= 1'b0;
  end
endmodule

// ===== sv/tile_layout_tree_parser_unit.sv =====
// Tile layout tree parser.
// Input channel: push a reply byte with in_reply_byte and in_final_byte while
// full is low. Result channel: while empty is low, the oldest result waits on
// the out_ ports; pop takes it. Each placed square gives one square result, a
// final byte adds a verdict with out_run_end set on the last result of a byte.
// Steps: each byte passes S_READ and S_DECIDE in the engine; an empty side
// also unwinds through S_RWAIT, and each further closed frame popped from the
// stack memory adds another S_RWAIT, S_READ and S_DECIDE pass. A square byte
// scans every stored position through one memory read port, then passes
// S_PLACE and S_EMIT; a verdict adds S_VERD. The engine takes a new byte only
// after it is done with the last; a two-entry request queue in front takes
// bytes while the engine works.
// Reset empties both queues, restarts the reply and sets square_limit to 64.
// A stalled sink holds the engine at its result; requests wait in the queue.
// Configuration: register square_limit at address 0 of the psel/penable port.
module tile_layout_tree_parser_unit import tltp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_reply_byte,
  input  logic        in_final_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_result_kind,
  output logic signed [7:0] out_pos_x,
  output logic signed [7:0] out_pos_y,
  output logic        out_verdict,
  output logic [6:0]  out_square_total,
  output logic        out_run_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [1:0] AddrLimit = 2'd0;
  logic [6:0] limit_r;
  req_t qd;
  logic qv, qpop, bv, btake;
  res_t bres, ores;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrLimit) ? {25'd0, limit_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= 7'd64;
    else if (psel && penable && pwrite && paddr == AddrLimit) limit_r <= pwdata[6:0];
  end

  tltp_front u_front (.clk(clk), .rst_n(rst_n), .push(push),
    .push_data(req_t'{in_reply_byte, in_final_byte}), .full(full),
    .pop(qpop), .pop_data(qd), .nempty(qv));
  tltp_back u_back (.clk(clk), .rst_n(rst_n), .limit(limit_r), .req_valid(qv),
    .req(qd), .req_pop(qpop), .res_valid(bv), .res(bres), .res_take(btake));
  tltp_outq u_outq (.clk(clk), .rst_n(rst_n), .in_valid(bv), .in_res(bres),
    .in_take(btake), .empty(empty), .out_res(ores), .pop(pop));

  assign out_result_kind = ores.kind;
  assign out_pos_x = ores.px;
  assign out_pos_y = ores.py;
  assign out_verdict = ores.verdict;
  assign out_square_total = ores.total;
  assign out_run_end = ores.last;
endmodule

// ===== sv/tltp_checker.sv =====
`include "tile_layout_tree_parser_unit_assert.svh"
module tltp_checker (
  input logic clk,
  input logic rst_n,
  input logic empty,
  input logic pop,
  input logic out_result_kind,
  input logic signed [7:0] out_pos_x,
  input logic out_verdict,
  input logic [6:0] out_square_total,
  input logic out_run_end
);
  `TLTP_ASSERT_IMP(a_verd_last, clk, rst_n, !empty && out_result_kind, out_run_end)
  `TLTP_ASSERT_IMP(a_rej_zero, clk, rst_n, !empty && out_result_kind && out_verdict,
    out_square_total == 7'd0)
  `TLTP_ASSERT_IMP(a_sq_clean, clk, rst_n, !empty && !out_result_kind,
    !out_verdict && out_square_total == 7'd0)
  `TLTP_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_pos_x))
endmodule

bind tile_layout_tree_parser_unit tltp_checker u_chk (.clk(clk), .rst_n(rst_n),
  .empty(empty), .pop(pop), .out_result_kind(out_result_kind),
  .out_pos_x(out_pos_x), .out_verdict(out_verdict),
  .out_square_total(out_square_total), .out_run_end(out_run_end));
